// File: sv/rwpf_pkg.sv
// rwpf_pkg: shared types and constants of the ray/wall position fix block.
// No dependencies; imported by every module of the block.
`default_nettype none
package rwpf_pkg;

  // heading angle format: full circle is 2^ANGLE_BITS
  localparam int ANGLE_BITS = 16;
  localparam int QUARTER    = 1 << (ANGLE_BITS - 2);

  localparam int NUM_SENS   = 3;
  localparam int SENS_FRONT = 0;
  localparam int SENS_LEFT  = 1;
  localparam int SENS_RIGHT = 2;

  // wall order of the ray test: bit 1 = x wall, bit 0 = high wall
  localparam logic [1:0] WALL_Y_MIN = 2'd0;
  localparam logic [1:0] WALL_Y_MAX = 2'd1;
  localparam logic [1:0] WALL_X_MIN = 2'd2;
  localparam logic [1:0] WALL_X_MAX = 2'd3;

  // fix source codes
  localparam logic [1:0] SRC_ODO   = 2'd0;
  localparam logic [1:0] SRC_FRONT = 2'd1;
  localparam logic [1:0] SRC_SIDE  = 2'd2;

  // config register indexes
  localparam logic [2:0] CFG_FIELD_MIN  = 3'd0;
  localparam logic [2:0] CFG_FIELD_MAX  = 3'd1;
  localparam logic [2:0] CFG_MAX_DIST   = 3'd2;
  localparam logic [2:0] CFG_FRONT_OFSX = 3'd3;
  localparam logic [2:0] CFG_FRONT_OFSY = 3'd4;
  localparam logic [2:0] CFG_SIDE_OFSX  = 3'd5;
  localparam logic [2:0] CFG_SIDE_OFSY  = 3'd6;

  localparam logic signed [13:0] RST_FIELD_MIN  = -14'sd4512;
  localparam logic        [12:0] RST_FIELD_MAX  = 13'd4512;
  localparam logic        [14:0] RST_MAX_DIST   = 15'd24960;
  localparam logic signed [10:0] RST_FRONT_OFSX = -11'sd320;
  localparam logic signed [10:0] RST_FRONT_OFSY = 11'sd320;
  localparam logic signed [10:0] RST_SIDE_OFSX  = 11'sd240;
  localparam logic signed [10:0] RST_SIDE_OFSY  = -11'sd320;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic signed [13:0] wall_lo;
    logic        [12:0] wall_hi;
    logic        [14:0] reading_limit;
    logic signed [10:0] front_offset_x;
    logic signed [10:0] front_offset_y;
    logic signed [10:0] side_offset_x;
    logic signed [10:0] side_offset_y;
  } cfg_t;

  // classified item: reading/ok indexed by SENS_*
  typedef struct packed {
    logic        [15:0]       heading;
    logic signed [15:0]       odo_x;
    logic signed [15:0]       odo_y;
    logic [NUM_SENS-1:0][14:0] reading;
    logic [NUM_SENS-1:0]       ok;
  } item_t;

endpackage
`default_nettype wire

// File: sv/rwpf_front.sv
// rwpf_front: input beat register; unpacks the stream beat and marks usable readings.
// Depends on rwpf_pkg.
`default_nettype none
module rwpf_front import rwpf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,
  input  logic [2:0]  s_tuser,
  output logic        out_valid,
  input  logic        out_ready,
  output item_t       out_item
);

  logic  hold_valid;
  item_t hold;
  item_t item_d;

  always_comb begin
    item_d.heading = s_tdata[15:0];
    item_d.odo_x   = s_tdata[31:16];
    item_d.odo_y   = s_tdata[47:32];
    item_d.reading[SENS_FRONT] = s_tdata[62:48];
    item_d.reading[SENS_LEFT]  = s_tdata[77:63];
    item_d.reading[SENS_RIGHT] = s_tdata[92:78];
    for (int i = 0; i < NUM_SENS; i++) begin
      // installed, nonzero and within range
      item_d.ok[i] = s_tuser[i] && (item_d.reading[i] != '0) &&
                     (item_d.reading[i] <= cfg.reading_limit);
    end
  end

  assign s_tready  = !hold_valid || out_ready;
  assign out_valid = hold_valid;
  assign out_item  = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tready) begin
      hold_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      hold <= item_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/rwpf_queue.sv
// rwpf_queue: short FIFO of classified items between front and back.
// Depends on rwpf_pkg.
`default_nettype none
module rwpf_queue import rwpf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign in_ready  = count != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_item  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= in_item;
  end

endmodule
`default_nettype wire

// File: sv/rwpf_back.sv
// rwpf_back: fixed pipeline: sin/cos, offset rotation, wall ray test, fix and fusion.
// Depends on rwpf_pkg.
`default_nettype none
module rwpf_back import rwpf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  item_t              in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] est_x,
  output logic signed [15:0] est_y,
  output logic [1:0]         x_source,
  output logic [1:0]         y_source
);

  localparam int NST = 13;

  typedef struct packed {
    logic signed [15:0]        px;
    logic signed [15:0]        py;
    logic [NUM_SENS-1:0][14:0] reading;
    logic [NUM_SENS-1:0]       ok;
  } base_t;

  typedef struct packed {
    logic signed [17:0] lx;
    logic signed [17:0] ly;
    logic signed [17:0] ux;
    logic signed [17:0] uy;
  } geo_t;

  typedef struct packed {
    logic        ok;
    logic [18:0] an;
    logic [17:0] ad;
  } wall_t;

  typedef struct packed {
    logic        have;
    logic [18:0] num;
    logic [17:0] den;
    logic [1:0]  idx;
  } kept_t;

  function automatic logic [16:0] sin_x(input logic [ANGLE_BITS-1:0] a);
    logic [ANGLE_BITS-2:0] r;
    logic [39:0]           wide;
    r = {1'b0, a[ANGLE_BITS-3:0]};
    if (a[ANGLE_BITS-2]) r = (ANGLE_BITS - 1)'(QUARTER) - r;
    wide = (40'(r) << 15) >> (ANGLE_BITS - 2);
    return wide[16:0];
  endfunction

  // round half away from zero, divide by 2^15
  function automatic logic signed [25:0] rnd15(input logic signed [39:0] v);
    logic [39:0] mag;
    logic [39:0] r;
    mag = v[39] ? 40'(-v) : 40'(v);
    r   = (mag + 40'd16384) >> 15;
    return v[39] ? -$signed(26'(r)) : $signed(26'(r));
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767)  return 16'sh7fff;
    if (v < -20'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic kept_t fold(input kept_t k, input wall_t w, input logic [1:0] idx);
    kept_t r;
    logic  nearer;
    r      = k;
    nearer = (37'(w.an) * 37'(k.den)) < (37'(k.num) * 37'(w.ad));
    if (w.ok && (!k.have || nearer)) begin
      r.have = 1'b1;
      r.num  = w.an;
      r.den  = w.ad;
      r.idx  = idx;
    end
    return r;
  endfunction

  logic           en;
  logic [NST-1:0] vld;
  base_t          base_p [NST];

  // sin (index 0) and cos (index 1) chain
  logic [16:0]        a_x   [2];
  logic [1:0]         a_neg;
  logic [15:0]        b_x2  [2];
  logic [16:0]        b_x   [2];
  logic [1:0]         b_neg;
  logic [15:0]        c_inner [2];
  logic [15:0]        c_x2  [2];
  logic [16:0]        c_x   [2];
  logic [1:0]         c_neg;
  logic [16:0]        d_mid [2];
  logic [16:0]        d_x   [2];
  logic [1:0]         d_neg;
  logic signed [17:0] e_sc  [2];

  // rotation
  logic signed [11:0] ox [NUM_SENS];
  logic signed [11:0] oy [NUM_SENS];
  logic signed [31:0] f_px [NUM_SENS];
  logic signed [31:0] f_py [NUM_SENS];
  logic signed [17:0] f_s;
  logic signed [17:0] f_c;

  logic signed [17:0] g_sx [NUM_SENS];
  logic signed [17:0] g_sy [NUM_SENS];
  geo_t               geo_d [NUM_SENS];
  geo_t               geo_p [6:11][NUM_SENS];

  // ray test
  logic               h_pre_d  [NUM_SENS][4];
  logic [18:0]        h_an_d   [NUM_SENS][4];
  logic [17:0]        h_ad_d   [NUM_SENS][4];
  logic signed [39:0] h_p1_d   [NUM_SENS][4];
  logic signed [39:0] h_p2_d   [NUM_SENS][4];
  logic signed [39:0] h_pmin_d [NUM_SENS][4];
  logic signed [39:0] h_pmax_d [NUM_SENS][4];
  logic               h_pre  [NUM_SENS][4];
  logic [18:0]        h_an   [NUM_SENS][4];
  logic [17:0]        h_ad   [NUM_SENS][4];
  logic signed [39:0] h_p1   [NUM_SENS][4];
  logic signed [39:0] h_p2   [NUM_SENS][4];
  logic signed [39:0] h_pmin [NUM_SENS][4];
  logic signed [39:0] h_pmax [NUM_SENS][4];

  wall_t [3:0] w_p [8:10][NUM_SENS];
  kept_t       k_p [9:11][NUM_SENS];

  logic signed [39:0] m_prod [NUM_SENS];
  logic signed [17:0] m_l    [NUM_SENS];
  logic [1:0]         m_idx  [NUM_SENS];
  logic [NUM_SENS-1:0] m_fix;

  logic signed [19:0] n_pos [NUM_SENS];
  logic signed [19:0] ex;
  logic signed [19:0] ey;
  logic [1:0]         xs;
  logic [1:0]         ys;

  // whole pipeline advances unless the output register holds an untaken beat
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[NST-2:0], in_valid};
      out_valid <= vld[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base_p[0].px      <= in_item.odo_x;
      base_p[0].py      <= in_item.odo_y;
      base_p[0].reading <= in_item.reading;
      base_p[0].ok      <= in_item.ok;
      for (int i = 1; i < NST; i++) base_p[i] <= base_p[i-1];
    end
  end

  // stages 0..4: quarter-wave polynomial for sin(h) and cos(h)
  always_ff @(posedge clk) begin
    if (en) begin
      a_x[0]   <= sin_x(in_item.heading[ANGLE_BITS-1:0]);
      a_x[1]   <= sin_x(in_item.heading[ANGLE_BITS-1:0] + ANGLE_BITS'(QUARTER));
      a_neg[0] <= in_item.heading[ANGLE_BITS-1];
      a_neg[1] <= 1'(((in_item.heading[ANGLE_BITS-1:0] + ANGLE_BITS'(QUARTER))
                      >> (ANGLE_BITS - 1)));
      for (int i = 0; i < 2; i++) begin
        b_x2[i]    <= 16'((34'(a_x[i]) * 34'(a_x[i])) >> 15);
        b_x[i]     <= a_x[i];
        c_inner[i] <= 16'(17'd42047 - 17'((32'(b_x2[i]) * 32'd4640) >> 15));
        c_x2[i]    <= b_x2[i];
        c_x[i]     <= b_x[i];
        d_mid[i]   <= 17'(18'd102944 - 18'((32'(c_x2[i]) * 32'(c_inner[i])) >> 15));
        d_x[i]     <= c_x[i];
      end
      b_neg <= a_neg;
      c_neg <= b_neg;
      d_neg <= c_neg;
    end
  end

  always_ff @(posedge clk) begin
    logic [33:0] p;
    logic [17:0] s;
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        p = 34'(d_x[i]) * 34'(d_mid[i]);
        s = (p[33:16] > 18'd32768) ? 18'd32768 : p[33:16];
        e_sc[i] <= d_neg[i] ? -$signed(s) : $signed(s);
      end
    end
  end

  // stage 5: rotate mount offsets; left uses the negated side x offset
  always_comb begin
    ox[SENS_FRONT] = 12'(cfg.front_offset_x);
    oy[SENS_FRONT] = 12'(cfg.front_offset_y);
    ox[SENS_LEFT]  = -12'(cfg.side_offset_x);
    oy[SENS_LEFT]  = 12'(cfg.side_offset_y);
    ox[SENS_RIGHT] = 12'(cfg.side_offset_x);
    oy[SENS_RIGHT] = 12'(cfg.side_offset_y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NUM_SENS; s++) begin
        f_px[s] <= ox[s] * e_sc[1] + oy[s] * e_sc[0];
        f_py[s] <= oy[s] * e_sc[1] - ox[s] * e_sc[0];
      end
      f_s <= e_sc[0];
      f_c <= e_sc[1];
    end
  end

  // stage 6: sensor origin and ray direction
  always_comb begin
    for (int s = 0; s < NUM_SENS; s++) begin
      geo_d[s].lx = 18'(rnd15(40'(f_px[s])));
      geo_d[s].ly = 18'(rnd15(40'(f_py[s])));
    end
    geo_d[SENS_FRONT].ux = f_s;
    geo_d[SENS_FRONT].uy = f_c;
    geo_d[SENS_LEFT].ux  = -f_c;
    geo_d[SENS_LEFT].uy  = f_s;
    geo_d[SENS_RIGHT].ux = f_c;
    geo_d[SENS_RIGHT].uy = -f_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NUM_SENS; s++) begin
        g_sx[s]     <= 18'(base_p[5].px) + geo_d[s].lx;
        g_sy[s]     <= 18'(base_p[5].py) + geo_d[s].ly;
        geo_p[6][s] <= geo_d[s];
      end
      for (int i = 7; i <= 11; i++) geo_p[i] <= geo_p[i-1];
    end
  end

  // stage 7: per wall products of the hit-span test
  always_comb begin
    logic signed [17:0] a0;
    logic signed [17:0] b0;
    logic signed [17:0] da;
    logic signed [17:0] db;
    logic signed [18:0] w;
    logic signed [18:0] n;
    for (int s = 0; s < NUM_SENS; s++) begin
      for (int k = 0; k < 4; k++) begin
        if (k < 2) begin
          a0 = g_sy[s];
          b0 = g_sx[s];
          da = geo_p[6][s].uy;
          db = geo_p[6][s].ux;
        end else begin
          a0 = g_sx[s];
          b0 = g_sy[s];
          da = geo_p[6][s].ux;
          db = geo_p[6][s].uy;
        end
        w = (k % 2 == 1) ? $signed(19'(cfg.wall_hi)) : 19'(cfg.wall_lo);
        n = w - 19'(a0);
        h_pre_d[s][k]  = (da != '0) && (n != '0) && (n[18] == da[17]);
        h_an_d[s][k]   = n[18] ? 19'(-n) : 19'(n);
        h_ad_d[s][k]   = da[17] ? 18'(-da) : 18'(da);
        h_p1_d[s][k]   = b0 * $signed({1'b0, h_ad_d[s][k]});
        h_p2_d[s][k]   = $signed({1'b0, h_an_d[s][k]}) * db;
        h_pmin_d[s][k] = cfg.wall_lo * $signed({1'b0, h_ad_d[s][k]});
        h_pmax_d[s][k] = $signed({1'b0, cfg.wall_hi}) * $signed({1'b0, h_ad_d[s][k]});
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [39:0] hn;
    if (en) begin
      h_pre  <= h_pre_d;
      h_an   <= h_an_d;
      h_ad   <= h_ad_d;
      h_p1   <= h_p1_d;
      h_p2   <= h_p2_d;
      h_pmin <= h_pmin_d;
      h_pmax <= h_pmax_d;
      // stage 8: hit must land inside the field span
      for (int s = 0; s < NUM_SENS; s++) begin
        for (int k = 0; k < 4; k++) begin
          hn = h_p1[s][k] + h_p2[s][k];
          w_p[8][s][k].ok <= h_pre[s][k] && (hn >= h_pmin[s][k]) && (hn <= h_pmax[s][k]);
          w_p[8][s][k].an <= h_an[s][k];
          w_p[8][s][k].ad <= h_ad[s][k];
        end
      end
      w_p[9]  <= w_p[8];
      w_p[10] <= w_p[9];
      // stages 9..11: nearest hit, later wall wins only when strictly nearer
      for (int s = 0; s < NUM_SENS; s++) begin
        k_p[9][s]  <= fold(fold('0, w_p[8][s][0], WALL_Y_MIN), w_p[8][s][1], WALL_Y_MAX);
        k_p[10][s] <= fold(k_p[9][s], w_p[9][s][2], WALL_X_MIN);
        k_p[11][s] <= fold(k_p[10][s], w_p[10][s][3], WALL_X_MAX);
      end
    end
  end

  // stage 12: distance along the hit wall's axis
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NUM_SENS; s++) begin
        m_prod[s] <= $signed({1'b0, base_p[11].reading[s]}) *
                     (k_p[11][s].idx[1] ? geo_p[11][s].ux : geo_p[11][s].uy);
        m_l[s]    <= k_p[11][s].idx[1] ? geo_p[11][s].lx : geo_p[11][s].ly;
        m_idx[s]  <= k_p[11][s].idx;
        m_fix[s]  <= k_p[11][s].have && base_p[11].ok[s];
      end
    end
  end

  // output stage: position, side fusion, overrides
  always_comb begin
    logic signed [19:0] wall;
    logic               side_left;
    int                 sd;
    for (int s = 0; s < NUM_SENS; s++) begin
      wall = m_idx[s][0] ? $signed(20'(cfg.wall_hi)) : 20'(cfg.wall_lo);
      n_pos[s] = wall - 20'(rnd15(m_prod[s])) - 20'(m_l[s]);
    end
    if (m_fix[SENS_LEFT] && m_fix[SENS_RIGHT]) begin
      side_left = base_p[12].reading[SENS_LEFT] < base_p[12].reading[SENS_RIGHT];
    end else begin
      side_left = m_fix[SENS_LEFT];
    end
    sd = side_left ? SENS_LEFT : SENS_RIGHT;
    ex = 20'(base_p[12].px);
    ey = 20'(base_p[12].py);
    xs = SRC_ODO;
    ys = SRC_ODO;
    if (m_fix[SENS_FRONT]) begin
      if (m_idx[SENS_FRONT][1]) begin
        ex = n_pos[SENS_FRONT];
        xs = SRC_FRONT;
      end else begin
        ey = n_pos[SENS_FRONT];
        ys = SRC_FRONT;
      end
    end
    if (m_fix[SENS_LEFT] || m_fix[SENS_RIGHT]) begin
      if (m_idx[sd][1]) begin
        ex = n_pos[sd];
        xs = SRC_SIDE;
      end else begin
        ey = n_pos[sd];
        ys = SRC_SIDE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      est_x    <= sat16(ex);
      est_y    <= sat16(ey);
      x_source <= xs;
      y_source <= ys;
    end
  end

endmodule
`default_nettype wire

// File: sv/ray_wall_position_fix_core.sv
// ray_wall_position_fix_core: top level; config registers, front, queue and back.
// Depends on rwpf_pkg, rwpf_front, rwpf_queue, rwpf_back.
//
// Absolute position fix from three wall distance sensors (front, left, right).
// Each input beat carries a heading, an odometry position and the three
// readings; each beat yields exactly one output beat with the estimated x/y
// and a source code per axis (0 odometry, 1 front, 2 side). The block takes
// one beat per clock unless the output stalls: a front register unpacks the
// beat and flags usable readings, a four-entry queue decouples it from a
// 13-stage back pipeline (sin/cos polynomial, offset rotation, wall ray test,
// nearest-hit fold, fix and fusion) that ends in an output register.
// Sustained rate is one beat per cycle, limited only by downstream tready.
// Config registers are written through the cfg port (always ready); the user
// must write them only while no beat is in flight, which the block does not
// enforce itself; an index of 7 is ignored.
`default_nettype none
module ray_wall_position_fix_core import rwpf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] heading, [31:16] odo_x, [47:32] odo_y, [62:48] front_distance,
  // [77:63] left_distance, [92:78] right_distance, [95:93] zero
  input  logic [95:0] s_tdata,
  // [0] front_present, [1] left_present, [2] right_present
  input  logic [2:0]  s_tuser,
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] est_x, [31:16] est_y
  output logic [31:0] m_tdata,
  // [1:0] x_source, [3:2] y_source
  output logic [3:0]  m_tuser
);

  cfg_t  cfg;
  logic  fq_valid;
  logic  fq_ready;
  item_t fq_item;
  logic  qb_valid;
  logic  qb_ready;
  item_t qb_item;
  logic signed [15:0] est_x;
  logic signed [15:0] est_y;
  logic [1:0]         x_source;
  logic [1:0]         y_source;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wall_lo        <= RST_FIELD_MIN;
      cfg.wall_hi        <= RST_FIELD_MAX;
      cfg.reading_limit  <= RST_MAX_DIST;
      cfg.front_offset_x <= RST_FRONT_OFSX;
      cfg.front_offset_y <= RST_FRONT_OFSY;
      cfg.side_offset_x  <= RST_SIDE_OFSX;
      cfg.side_offset_y  <= RST_SIDE_OFSY;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FIELD_MIN:  cfg.wall_lo        <= cfg_data[13:0];
        CFG_FIELD_MAX:  cfg.wall_hi        <= cfg_data[12:0];
        CFG_MAX_DIST:   cfg.reading_limit  <= cfg_data;
        CFG_FRONT_OFSX: cfg.front_offset_x <= cfg_data[10:0];
        CFG_FRONT_OFSY: cfg.front_offset_y <= cfg_data[10:0];
        CFG_SIDE_OFSX:  cfg.side_offset_x  <= cfg_data[10:0];
        CFG_SIDE_OFSY:  cfg.side_offset_y  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  rwpf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .out_valid (fq_valid),
    .out_ready (fq_ready),
    .out_item  (fq_item)
  );

  rwpf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  rwpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (qb_valid),
    .in_ready  (qb_ready),
    .in_item   (qb_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .est_x     (est_x),
    .est_y     (est_y),
    .x_source  (x_source),
    .y_source  (y_source)
  );

  assign m_tdata = {est_y, est_x};
  assign m_tuser = {y_source, x_source};

endmodule
`default_nettype wire
